>>> hdl/lang_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lang_pkg;

	localparam int RATE_W    = 32;
	localparam int LEVEL_W   = 31;
	localparam int DT_W      = 17;
	localparam int NOISE_W   = 32;
	localparam int ROOT_W    = 32;
	localparam int ROOT_IN_W = 2 * ROOT_W;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int MUL_W     = 32;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int STEP_CNT_W = 4;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
	localparam logic [DT_W-1:0]    DT_RESET  = DT_W'(655);

	// register indexes
	localparam logic [2:0] REG_DECAY   = 3'd0;
	localparam logic [2:0] REG_PDECAY  = 3'd1;
	localparam logic [2:0] REG_TRANSL  = 3'd2;
	localparam logic [2:0] REG_DT      = 3'd3;
	localparam logic [2:0] REG_M0      = 3'd4;

	localparam logic CMD_RESTART = 1'b0;

	// last issue slot of the drift phase
	localparam logic [STEP_CNT_W-1:0] STEP_LAST       = STEP_CNT_W'(8);
	localparam logic [STEP_CNT_W-1:0] STEP_ROOT_START = STEP_CNT_W'(4);

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_A,
		MUL_B,
		MUL_C,
		MUL_ADT_LO,
		MUL_ADT_HI,
		MUL_BDT_LO,
		MUL_BDT_HI,
		MUL_CDT_LO,
		MUL_CDT_HI,
		MUL_NM,
		MUL_NP
	} mul_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RESTART,
		ST_DRIFT,
		ST_ROOT_WAIT,
		ST_NOISE_M,
		ST_NOISE_P,
		ST_DRAIN,
		ST_SETTLE
	} state_t;

	typedef struct packed {
		logic    load_item;
		logic    restart;
		logic    settle;
		logic    root_start;
		mul_op_t mul_op;
	} dp_cmd_t;

	typedef struct packed {
		logic roots_done;
	} dp_status_t;

endpackage
`default_nettype wire

>>> hdl/lang_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module lang_sqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [lang_pkg::ROOT_IN_W-1:0] x,
	output logic                               busy,
	output logic [lang_pkg::ROOT_W-1:0]        root
);
	import lang_pkg::*;

	localparam int REM_W = ROOT_W + 3;
	localparam int CNT_W = $clog2(ROOT_W);

	logic [ROOT_IN_W-1:0] x_q;
	logic [REM_W-1:0]     rem_q;
	logic [ROOT_W-1:0]    root_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             fits;

	// one result bit per cycle, restoring
	assign rem_sh = {rem_q[REM_W-3:0], x_q[ROOT_IN_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(ROOT_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= x_q << 2;
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule
`default_nettype wire

>>> hdl/lang_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module lang_dpath #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire lang_pkg::dp_cmd_t            cmd,
	output lang_pkg::dp_status_t              status,
	input  wire logic [lang_pkg::NOISE_W-1:0] noise_mrna,
	input  wire logic [lang_pkg::NOISE_W-1:0] noise_protein,
	input  wire logic [lang_pkg::RATE_W-1:0]  decay_rate,
	input  wire logic [lang_pkg::RATE_W-1:0]  protein_decay_rate,
	input  wire logic [lang_pkg::RATE_W-1:0]  translation_rate,
	input  wire logic [lang_pkg::DT_W-1:0]    time_step,
	input  wire logic [lang_pkg::LEVEL_W-1:0] initial_mrna,
	output logic [lang_pkg::LEVEL_W-1:0]      mrna_level,
	output logic [lang_pkg::LEVEL_W-1:0]      protein_level
);
	import lang_pkg::*;

	// rate*level product width after the fraction shift
	localparam int AW = PROD_W - 1 - FRAC_BITS;
	// width of the positive and negative sums
	localparam int SW = PROD_W + 1 - FRAC_BITS;
	localparam logic [MUL_W-1:0] ONE = MUL_W'(1) << FRAC_BITS;

	function automatic logic [LEVEL_W-1:0] settle(input logic [SW-1:0] pos,
	                                               input logic [SW-1:0] neg);
		logic [SW-1:0] d;
		d = pos - neg;
		if (pos <= neg) begin
			return '0;
		end else if (d > SW'(LEVEL_MAX)) begin
			return LEVEL_MAX;
		end
		return d[LEVEL_W-1:0];
	endfunction

	logic [LEVEL_W-1:0] m_q, p_q;
	logic [NOISE_W-1:0] mag_m_q, mag_p_q;
	logic               neg_m_q, neg_p_q;
	logic [AW-1:0]      a_q, b_q, c_q;
	logic [PROD_W-1:0]  acc_q;
	logic [SW-1:0]      mpos_q, mneg_q, ppos_q, pneg_q;
	logic [PROD_W-1:0]  prod_s1;
	mul_op_t            op_s1;

	logic [DT_W-1:0]    dt;
	logic [MUL_W-1:0]   op_x, op_y;
	logic [PROD_W-1:0]  drift_full;
	logic [SW-1:0]      drift;
	logic [SW-1:0]      term;
	logic [ROOT_IN_W-1:0] root_in_m, root_in_p;
	logic [ROOT_W-1:0]  root_m, root_p;
	logic               busy_m, busy_p;

	assign dt = ({{(MUL_W - DT_W){1'b0}}, time_step} > ONE) ? ONE[DT_W-1:0] : time_step;

	always_comb begin
		op_x = '0;
		op_y = '0;
		case (cmd.mul_op)
			MUL_A: begin
				op_x = decay_rate;
				op_y = MUL_W'(m_q);
			end
			MUL_B: begin
				op_x = translation_rate;
				op_y = MUL_W'(m_q);
			end
			MUL_C: begin
				op_x = protein_decay_rate;
				op_y = MUL_W'(p_q);
			end
			MUL_ADT_LO: begin
				op_x = a_q[MUL_W-1:0];
				op_y = MUL_W'(dt);
			end
			MUL_ADT_HI: begin
				op_x = MUL_W'(a_q[AW-1:MUL_W]);
				op_y = MUL_W'(dt);
			end
			MUL_BDT_LO: begin
				op_x = b_q[MUL_W-1:0];
				op_y = MUL_W'(dt);
			end
			MUL_BDT_HI: begin
				op_x = MUL_W'(b_q[AW-1:MUL_W]);
				op_y = MUL_W'(dt);
			end
			MUL_CDT_LO: begin
				op_x = c_q[MUL_W-1:0];
				op_y = MUL_W'(dt);
			end
			MUL_CDT_HI: begin
				op_x = MUL_W'(c_q[AW-1:MUL_W]);
				op_y = MUL_W'(dt);
			end
			MUL_NM: begin
				op_x = root_m;
				op_y = mag_m_q;
			end
			MUL_NP: begin
				op_x = root_p;
				op_y = mag_p_q;
			end
			default: begin
				op_x = '0;
				op_y = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= MUL_NONE;
		end else begin
			op_s1 <= cmd.mul_op;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= {{(PROD_W - MUL_W){1'b0}}, op_x} * {{(PROD_W - MUL_W){1'b0}}, op_y};
	end

	// upper partial product lands 32 bits up
	assign drift_full = acc_q + (prod_s1 << MUL_W);
	assign drift      = SW'(drift_full >> FRAC_BITS);
	assign term       = SW'(prod_s1 >> FRAC_BITS);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			neg_m_q <= noise_mrna[NOISE_W-1];
			neg_p_q <= noise_protein[NOISE_W-1];
			mag_m_q <= noise_mrna[NOISE_W-1] ? -noise_mrna : noise_mrna;
			mag_p_q <= noise_protein[NOISE_W-1] ? -noise_protein : noise_protein;
		end
		case (op_s1)
			MUL_A: a_q <= AW'(prod_s1 >> FRAC_BITS);
			MUL_B: b_q <= AW'(prod_s1 >> FRAC_BITS);
			MUL_C: c_q <= AW'(prod_s1 >> FRAC_BITS);
			MUL_ADT_LO, MUL_BDT_LO, MUL_CDT_LO: acc_q <= prod_s1;
			MUL_ADT_HI: begin
				mneg_q <= drift;
				mpos_q <= SW'(m_q);
			end
			MUL_BDT_HI: ppos_q <= SW'(p_q) + drift;
			MUL_CDT_HI: pneg_q <= drift;
			MUL_NM: begin
				if (neg_m_q) begin
					mneg_q <= mneg_q + term;
				end else begin
					mpos_q <= mpos_q + term;
				end
			end
			MUL_NP: begin
				if (neg_p_q) begin
					pneg_q <= pneg_q + term;
				end else begin
					ppos_q <= ppos_q + term;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= '0;
			p_q <= '0;
		end else if (cmd.restart) begin
			m_q <= initial_mrna;
			p_q <= '0;
		end else if (cmd.settle) begin
			m_q <= settle(mpos_q, mneg_q);
			p_q <= settle(ppos_q, pneg_q);
		end
	end

	assign root_in_m = ROOT_IN_W'(a_q) << FRAC_BITS;
	assign root_in_p = (ROOT_IN_W'(b_q) + ROOT_IN_W'(c_q)) << FRAC_BITS;

	lang_sqrt u_sqrt_m (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.root_start),
		.x      (root_in_m),
		.busy   (busy_m),
		.root   (root_m)
	);

	lang_sqrt u_sqrt_p (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.root_start),
		.x      (root_in_p),
		.busy   (busy_p),
		.root   (root_p)
	);

	assign status.roots_done = !busy_m && !busy_p;
	assign mrna_level        = m_q;
	assign protein_level     = p_q;

endmodule
`default_nettype wire

>>> hdl/lang_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lang_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic           command,
	output logic                out_valid,
	input  wire logic           out_stall,
	output lang_pkg::dp_cmd_t   cmd,
	input  wire lang_pkg::dp_status_t status
);
	import lang_pkg::*;

	state_t                state_q, state_d;
	logic [STEP_CNT_W-1:0] step_q;
	logic                  out_valid_q;
	logic                  slot_free;
	logic                  publish;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (command == CMD_RESTART) ? ST_RESTART : ST_DRIFT;
				end
			end
			ST_RESTART: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_DRIFT: begin
				if (step_q == STEP_LAST) begin
					state_d = ST_ROOT_WAIT;
				end
			end
			ST_ROOT_WAIT: begin
				if (status.roots_done) begin
					state_d = ST_NOISE_M;
				end
			end
			ST_NOISE_M: state_d = ST_NOISE_P;
			ST_NOISE_P: state_d = ST_DRAIN;
			ST_DRAIN:   state_d = ST_SETTLE;
			ST_SETTLE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.mul_op = MUL_NONE;
		in_stall   = 1'b1;
		publish    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall      = 1'b0;
				cmd.load_item = in_valid;
			end
			ST_RESTART: begin
				cmd.restart = slot_free;
				publish     = slot_free;
			end
			ST_DRIFT: begin
				cmd.root_start = (step_q == STEP_ROOT_START);
				case (step_q)
					4'd0:    cmd.mul_op = MUL_A;
					4'd1:    cmd.mul_op = MUL_B;
					4'd2:    cmd.mul_op = MUL_C;
					4'd3:    cmd.mul_op = MUL_ADT_LO;
					4'd4:    cmd.mul_op = MUL_ADT_HI;
					4'd5:    cmd.mul_op = MUL_BDT_LO;
					4'd6:    cmd.mul_op = MUL_BDT_HI;
					4'd7:    cmd.mul_op = MUL_CDT_LO;
					4'd8:    cmd.mul_op = MUL_CDT_HI;
					default: cmd.mul_op = MUL_NONE;
				endcase
			end
			ST_NOISE_M: cmd.mul_op = MUL_NM;
			ST_NOISE_P: cmd.mul_op = MUL_NP;
			ST_SETTLE: begin
				cmd.settle = slot_free;
				publish    = slot_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= (state_q == ST_DRIFT) ? step_q + 1'b1 : '0;
			out_valid_q <= publish || (out_valid_q && out_stall);
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

>>> hdl/langevin_two_species_euler_step.sv
// Two-species (mRNA, protein) Euler-Maruyama step in unsigned fixed point.
// Input channel: in_valid / in_stall with command, noise_mrna, noise_protein.
// An item is taken at a clock edge with in_valid high and in_stall low.
// command 0 restarts (mrna = initial_mrna, protein = 0); command 1 steps.
// Output channel: out_valid / out_stall with mrna_level, protein_level;
// exactly one result per item, in order.
// A step item goes from acceptance to result through the drift terms on
// the shared 32x32 multiplier, then the two bit-serial square roots
// (started mid-way through the drift terms), then two noise products and
// the final clamp. A restart result is published from the restart state
// once the output slot is free.
// One item is in work at a time; the next is accepted once the previous
// result is registered, even while that result waits on out_stall.
// A result is held unchanged while out_stall is high; the next result is
// not published until it is taken. Reset clears both levels to zero and
// sets the registers to their defaults (time_step 655). Registers must be
// written over the APB port only while idle; the block does not check it.
`timescale 1ns / 1ps
`default_nettype none
module langevin_two_species_euler_step #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [lang_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [lang_pkg::DATA_W-1:0]  pwdata,
	output logic [lang_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         command,
	input  wire logic [lang_pkg::NOISE_W-1:0] noise_mrna,
	input  wire logic [lang_pkg::NOISE_W-1:0] noise_protein,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [lang_pkg::LEVEL_W-1:0]      mrna_level,
	output logic [lang_pkg::LEVEL_W-1:0]      protein_level
);
	import lang_pkg::*;

	logic [RATE_W-1:0]  decay_q, pdecay_q, transl_q;
	logic [DT_W-1:0]    dt_q;
	logic [LEVEL_W-1:0] m0_q;
	logic [2:0]         reg_idx;
	logic               wr_en;
	dp_cmd_t            cmd;
	dp_status_t         status;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q  <= '0;
			pdecay_q <= '0;
			transl_q <= '0;
			dt_q     <= DT_RESET;
			m0_q     <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DECAY:  decay_q  <= pwdata;
				REG_PDECAY: pdecay_q <= pwdata;
				REG_TRANSL: transl_q <= pwdata;
				REG_DT:     dt_q     <= pwdata[DT_W-1:0];
				REG_M0:     m0_q     <= pwdata[LEVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DECAY:  prdata = decay_q;
			REG_PDECAY: prdata = pdecay_q;
			REG_TRANSL: prdata = transl_q;
			REG_DT:     prdata = DATA_W'(dt_q);
			REG_M0:     prdata = DATA_W'(m0_q);
			default:    prdata = '0;
		endcase
	end

	lang_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	lang_dpath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.noise_mrna         (noise_mrna),
		.noise_protein      (noise_protein),
		.decay_rate         (decay_q),
		.protein_decay_rate (pdecay_q),
		.translation_rate   (transl_q),
		.time_step          (dt_q),
		.initial_mrna       (m0_q),
		.mrna_level         (mrna_level),
		.protein_level      (protein_level)
	);

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import lang_pkg::*;

	localparam int F = 16;
	localparam logic [63:0] ONE = 64'd1 << F;
	localparam longint unsigned CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 60;

	typedef struct {
		logic [LEVEL_W-1:0] mrna;
		logic [LEVEL_W-1:0] protein;
	} levels_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid, in_stall, command;
	logic [NOISE_W-1:0] noise_mrna, noise_protein;
	logic out_valid, out_stall;
	logic [LEVEL_W-1:0] mrna_level, protein_level;

	langevin_two_species_euler_step i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .command(command),
		.noise_mrna(noise_mrna), .noise_protein(noise_protein),
		.out_valid(out_valid), .out_stall(out_stall),
		.mrna_level(mrna_level), .protein_level(protein_level)
	);

	// predictor copy of registers and state
	logic [63:0] rate_delta, rate_gamma, rate_k, step_dt, start_mrna;
	logic [63:0] model_m, model_p;
	levels_t expected_levels[$];

	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int restarts_sent = 0;
	bit idle_on = 1;
	int hold_req = 0;
	longint unsigned cycles = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] isqrt64(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] probe;
		r = 0;
		probe = 64'd1 << 62;
		while (probe > x)
			probe = probe >> 2;
		while (probe != 0) begin
			if (x >= r + probe) begin
				x = x - (r + probe);
				r = (r >> 1) + probe;
			end else begin
				r = r >> 1;
			end
			probe = probe >> 2;
		end
		return r;
	endfunction

	// signed noise term root*w lands on the positive or negative side
	function automatic void apply_noise(logic [63:0] root, logic [31:0] w,
			inout logic [63:0] pos, inout logic [63:0] neg);
		logic [63:0] mag;
		logic [63:0] term;
		mag = w[31] ? ((64'd1 << 32) - {32'd0, w}) : {32'd0, w};
		term = (root * mag) >> F;
		if (w[31])
			neg = neg + term;
		else
			pos = pos + term;
	endfunction

	function automatic logic [63:0] clamp_level(logic [63:0] pos, logic [63:0] neg);
		if (pos <= neg)
			return 0;
		if (pos - neg > {33'd0, LEVEL_MAX})
			return {33'd0, LEVEL_MAX};
		return pos - neg;
	endfunction

	function automatic levels_t euler_predict(logic cmd, logic [31:0] w1, logic [31:0] w2);
		logic [63:0] dt, a, b, c, mpos, mneg, ppos, pneg;
		levels_t res;
		if (cmd == CMD_RESTART) begin
			model_m = start_mrna;
			model_p = 0;
		end else begin
			dt = step_dt > ONE ? ONE : step_dt;
			a = (rate_delta * model_m) >> F;
			b = (rate_k * model_m) >> F;
			c = (rate_gamma * model_p) >> F;
			mpos = model_m;
			mneg = (a * dt) >> F;
			ppos = model_p + ((b * dt) >> F);
			pneg = (c * dt) >> F;
			apply_noise(isqrt64(a << F), w1, mpos, mneg);
			apply_noise(isqrt64((b + c) << F), w2, ppos, pneg);
			model_m = clamp_level(mpos, mneg);
			model_p = clamp_level(ppos, pneg);
		end
		res.mrna = model_m[LEVEL_W-1:0];
		res.protein = model_p[LEVEL_W-1:0];
		return res;
	endfunction

	// result checker
	initial begin
		levels_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				results_seen++;
				if (expected_levels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result m=%h p=%h", mrna_level, protein_level);
				end else begin
					want = expected_levels.pop_front();
					if (want.mrna !== mrna_level || want.protein !== protein_level) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch #%0d: exp m=%h p=%h got m=%h p=%h",
								results_seen, want.mrna, want.protein,
								mrna_level, protein_level);
					end
				end
			end
		end
	end

	// result side stall: random bursts plus an optional long hold
	initial begin
		int burst;
		burst = 0;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				out_stall <= 1;
				hold_req--;
			end else if (!idle_on) begin
				out_stall <= 0;
			end else if (burst > 0) begin
				out_stall <= 1;
				burst--;
			end else if ($urandom_range(0, 9) == 0) begin
				burst = $urandom_range(0, 16);
				out_stall <= 1;
			end else begin
				out_stall <= 0;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_DECAY:  rate_delta = {32'd0, value};
			REG_PDECAY: rate_gamma = {32'd0, value};
			REG_TRANSL: rate_k = {32'd0, value};
			REG_DT:     step_dt = {47'd0, value[DT_W-1:0]};
			REG_M0:     start_mrna = {33'd0, value[LEVEL_W-1:0]};
			default: ;
		endcase
	endtask

	task automatic send_item(logic cmd, logic [31:0] w1, logic [31:0] w2);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 17);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		noise_mrna <= w1;
		noise_protein <= w2;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_levels.push_back(euler_predict(cmd, w1, w2));
		items_sent++;
		if (cmd == CMD_RESTART)
			restarts_sent++;
	endtask

	// stop offering and wait for every expected result, then let the block go quiet
	task automatic drain;
		in_valid <= 0;
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_noise();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'h8000_0000 | $urandom_range(0, 3);
			default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
		endcase
	endfunction

	function automatic logic [31:0] rand_rate();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 0;
			default: return $urandom_range(0, 4 << 16);
		endcase
	endfunction

	task automatic random_setup();
		reg_write(REG_DECAY, rand_rate());
		reg_write(REG_PDECAY, rand_rate());
		reg_write(REG_TRANSL, rand_rate());
		case ($urandom_range(0, 3))
			0: reg_write(REG_DT, $urandom_range(0, 17'h1FFFF));
			1: reg_write(REG_DT, $urandom_range(0, 1) ? 32'h1_0000 : 32'd0);
			default: reg_write(REG_DT, $urandom_range(1, 1 << 14));
		endcase
		reg_write(REG_M0, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 200 << 16));
	endtask

	task automatic test_directed;
		// zero rates: noise has no effect
		send_item(1, 32'h7FFF_FFFF, 32'h8000_0000);
		drain();
		reg_write(REG_M0, 32'h7FFF_FFFF);
		reg_write(REG_DECAY, 32'hFFFF_FFFF);
		reg_write(REG_TRANSL, 32'hFFFF_FFFF);
		reg_write(REG_PDECAY, 32'hFFFF_FFFF);
		reg_write(REG_DT, 32'h1FFFF);
		drain();
		// restart ignores noise, then overflow and negative clamps
		send_item(CMD_RESTART, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(1, 32'h8000_0000, 32'h8000_0000);
		send_item(CMD_RESTART, 32'h0, 32'h0);
		send_item(1, 32'hFFFF_FFFF, 32'h0000_0001);
		send_item(1, 32'h0, 32'h0);
		drain();
		reg_write(REG_DT, 32'h1_0000);
		reg_write(REG_DECAY, 32'h0001_0000);
		reg_write(REG_TRANSL, 32'h0002_0000);
		reg_write(REG_PDECAY, 32'h0000_8000);
		reg_write(REG_M0, 32'h0010_0000);
		send_item(CMD_RESTART, 32'h5555_5555, 32'hAAAA_AAAA);
		repeat (4) send_item(1, 32'h0001_0000, 32'hFFFF_0000);
		drain();
		reg_write(REG_DT, 32'h0);
		send_item(1, 32'h0002_0000, 32'h0002_0000);
		send_item(1, 32'hFFFE_0000, 32'hFFFE_0000);
		drain();
	endtask

	task automatic test_random_phases(int phases, int per_phase);
		repeat (phases) begin
			random_setup();
			send_item(CMD_RESTART, $urandom, $urandom);
			repeat (per_phase) begin
				if ($urandom_range(0, 19) == 0)
					send_item(CMD_RESTART, $urandom, $urandom);
				else
					send_item(1, rand_noise(), rand_noise());
			end
			drain();
		end
	endtask

	task automatic test_backpressure;
		hold_req = 400;
		idle_on = 0;
		repeat (40) send_item($urandom_range(0, 9) != 0, rand_noise(), rand_noise());
		idle_on = 1;
		drain();
	endtask

	task automatic test_no_idle;
		idle_on = 0;
		random_setup();
		send_item(CMD_RESTART, 0, 0);
		repeat (400) send_item($urandom_range(0, 29) != 0, rand_noise(), rand_noise());
		drain();
	endtask

	initial begin
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		in_valid = 0;
		command = 0;
		noise_mrna = 0;
		noise_protein = 0;
		rate_delta = 0;
		rate_gamma = 0;
		rate_k = 0;
		step_dt = 655;
		start_mrna = 0;
		model_m = 0;
		model_p = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		test_directed();
		test_random_phases(8, 180);
		test_backpressure();
		test_no_idle();

		$display("covered %0d items (%0d restarts), %0d results checked", items_sent,
			restarts_sent, results_seen);
		$display("register sweeps incl. zero/max rates, dt above one, long output hold");
		if (mismatches == 0 && expected_levels.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_levels.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/lang_pkg.sv
hdl/lang_sqrt.sv
hdl/lang_dpath.sv
hdl/lang_ctrl.sv
hdl/langevin_two_species_euler_step.sv
bench/tb_top.sv
